// ----- src/eswitch_light_mode_controller_defines.svh -----
`ifndef ESWITCH_LIGHT_MODE_CONTROLLER_DEFINES_SVH
`define ESWITCH_LIGHT_MODE_CONTROLLER_DEFINES_SVH

// Check sampled on aclk, masked while reset is asserted.
`define ELMC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check sampled on aclk, active through reset as well.
`define ELMC_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- src/elmc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package elmc_pkg;

    localparam int MODE_W       = 3;
    localparam int WINDOW_DEPTH = 4;
    localparam int SUM_W        = 8 + $clog2(WINDOW_DEPTH);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam int IN_SWITCH_BIT = 0;
    localparam int IN_SAMPLE_LSB = 1;

    localparam int OUT_MODE_LSB   = 0;
    localparam int OUT_LEVEL_LSB  = 3;
    localparam int OUT_FAST_BIT   = 11;
    localparam int OUT_GREEN_BIT  = 12;
    localparam int OUT_RED_BIT    = 13;
    localparam int OUT_BLINKS_LSB = 14;
    localparam int OUT_ASLEEP_BIT = 17;
    localparam int OUT_USED_W     = 18;

    localparam logic [7:0] DEBOUNCE_MASK = 8'b0000_1111;
    localparam logic [7:0] WINDOW_RESET  = 8'd170;
    localparam logic [2:0] CHECK_START   = 3'd4;
    localparam logic [2:0] MAX_BLINKS    = 3'd5;

    localparam logic [7:0] LEVEL_TABLE [8] = '{
        8'd0, 8'd1, 8'd3, 8'd12, 8'd40, 8'd125, 8'd255, 8'd255
    };
    localparam logic [7:0] FAST_TABLE = 8'b0011_1000;
    localparam logic [7:0] BLINK_MARKS [5] = '{
        8'd128, 8'd151, 8'd165, 8'd175, 8'd184
    };

    typedef enum logic [2:0] {
        CFG_LONG_PRESS  = 3'd0,
        CFG_RAMP        = 3'd1,
        CFG_TURBO       = 3'd2,
        CFG_LOW_THR     = 3'd3,
        CFG_CRIT_THR    = 3'd4,
        CFG_LOWBATT_DLY = 3'd5,
        CFG_GREEN_THR   = 3'd6,
        CFG_YELLOW_THR  = 3'd7
    } cfg_idx_t;

endpackage

`default_nettype wire

// ----- src/eswitch_light_mode_controller.sv -----
// Each input transfer's result is registered and appears on m_tvalid in the cycle after the transfer.
// Throughput: one tick per cycle while the output is not stalled; the whole tick update is single-pass logic
// between the accepted item and the result register.
// A new tick is taken whenever the result register is empty or being drained.
// Reset: synchronous, active low; asleep, mode 0, voltage window at 170,
// configuration registers at their power-on values.
`timescale 1ns / 1ps
`default_nettype none

module eswitch_light_mode_controller #(
    parameter int NUM_MODES = 7
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [0] switch_pressed, [8:1] adc_sample
    input  wire logic [elmc_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] adc_ready
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [2:0] mode_index, [10:3] pwm_level, [11] pwm_fast, [12] green_led,
    // [13] red_led, [16:14] battery_blinks, [17] asleep
    output logic [elmc_pkg::M_TDATA_W-1:0]        m_tdata,
    // [0] readout_done
    output logic                                  m_tuser,
    input  wire logic                             cfg_we,
    input  wire elmc_pkg::cfg_idx_t               cfg_index,
    input  wire logic [15:0]                      cfg_wdata
);
    import elmc_pkg::*;

    localparam logic [MODE_W-1:0] TOP_MODE = MODE_W'(NUM_MODES - 1);

    function automatic logic [MODE_W-1:0] step_up(input logic [MODE_W-1:0] m);
        logic [MODE_W:0] inc;
        inc = {1'b0, m} + 1'b1;
        return (inc >= (MODE_W + 1)'(NUM_MODES)) ? '0 : inc[MODE_W-1:0];
    endfunction

    function automatic logic [MODE_W-1:0] step_down(input logic [MODE_W-1:0] m);
        return (m == '0) ? TOP_MODE : m - 1'b1;
    endfunction

    logic [6:0]  long_press_reg;
    logic [6:0]  ramp_reg;
    logic [15:0] turbo_timeout_reg;
    logic [7:0]  low_thr_reg;
    logic [7:0]  crit_thr_reg;
    logic [7:0]  lowbatt_delay_reg;
    logic [7:0]  green_thr_reg;
    logic [7:0]  yellow_thr_reg;

    logic [7:0]        hist_reg,    hist_next;
    logic [7:0]        press_reg,   press_next;
    logic [7:0]        on_time_reg, on_time_next;
    logic [15:0]       turbo_reg,   turbo_next;
    logic [7:0]        lowc_reg,    lowc_next;
    logic [MODE_W-1:0] mode_reg,    mode_next;
    logic [2:0]        cd_reg,      cd_next;
    logic [7:0]        win_reg [WINDOW_DEPTH];
    logic [7:0]        win_next [WINDOW_DEPTH];
    logic              sleep_reg,   sleep_next;
    logic              fast_reg,    fast_next;
    logic              green_reg,   green_next;
    logic              red_reg,     red_next;
    logic              pend_reg,    pend_next;

    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg,  m_tuser_next;

    logic       accept;
    logic       raw;
    logic [7:0] sample;
    logic       done;
    logic [2:0] blinks;
    logic [7:0] level;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign raw      = s_tdata[IN_SWITCH_BIT];
    assign sample   = s_tdata[IN_SAMPLE_LSB +: 8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg    <= 7'd21;
            ramp_reg          <= 7'd21;
            turbo_timeout_reg <= 16'd5625;
            low_thr_reg       <= 8'd124;
            crit_thr_reg      <= 8'd114;
            lowbatt_delay_reg <= 8'd188;
            green_thr_reg     <= 8'd156;
            yellow_thr_reg    <= 8'd142;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LONG_PRESS:  long_press_reg    <= cfg_wdata[6:0];
                CFG_RAMP:        ramp_reg          <= cfg_wdata[6:0];
                CFG_TURBO:       turbo_timeout_reg <= cfg_wdata;
                CFG_LOW_THR:     low_thr_reg       <= cfg_wdata[7:0];
                CFG_CRIT_THR:    crit_thr_reg      <= cfg_wdata[7:0];
                CFG_LOWBATT_DLY: lowbatt_delay_reg <= cfg_wdata[7:0];
                CFG_GREEN_THR:   green_thr_reg     <= cfg_wdata[7:0];
                CFG_YELLOW_THR:  yellow_thr_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic            awake;
        logic [8:0]      lp_end;
        logic [8:0]      ramp_end;
        logic [8:0]      check_win;
        logic [SUM_W-1:0] sum;
        logic [7:0]      avg;
        logic [7:0]      thr;

        hist_next    = hist_reg;
        press_next   = press_reg;
        on_time_next = on_time_reg;
        turbo_next   = turbo_reg;
        lowc_next    = lowc_reg;
        mode_next    = mode_reg;
        cd_next      = cd_reg;
        win_next     = win_reg;
        sleep_next   = sleep_reg;
        fast_next    = fast_reg;
        green_next   = green_reg;
        red_next     = red_reg;
        pend_next    = pend_reg;
        done         = 1'b0;
        blinks       = '0;
        awake        = 1'b1;
        lp_end       = {2'b00, long_press_reg} + 9'd1;
        ramp_end     = {2'b00, long_press_reg} + {2'b00, ramp_reg};
        check_win    = {1'b0, long_press_reg, 1'b0};
        sum          = '0;
        avg          = '0;
        thr          = '0;

        if (sleep_reg) begin
            if ((hist_reg & DEBOUNCE_MASK) == '0 && raw) begin
                sleep_next = 1'b0;
            end else begin
                hist_next = {hist_reg[6:0], raw};
                awake     = 1'b0;
            end
        end

        if (awake) begin
            if (mode_reg == '0) begin
                on_time_next = '0;
            end else if (on_time_reg != 8'hFF) begin
                on_time_next = on_time_reg + 1'b1;
            end

            hist_next = {hist_reg[6:0], raw};

            if ((hist_next & DEBOUNCE_MASK) != '0) begin
                turbo_next = '0;
                lowc_next  = '0;
                if (press_reg != 8'hFF) begin
                    press_next = press_reg + 1'b1;
                end
                if ({1'b0, press_next} == lp_end && cd_reg == '0) begin
                    mode_next = step_down(mode_reg);
                    if ({1'b0, on_time_next} < check_win && mode_next == '0) begin
                        cd_next = CHECK_START;
                    end
                end else if ({1'b0, press_next} == ramp_end) begin
                    press_next = {1'b0, long_press_reg};
                end
            end else begin
                if (press_reg != '0 && press_reg < {1'b0, long_press_reg}) begin
                    mode_next = step_up(mode_reg);
                end else begin
                    if (mode_reg == TOP_MODE) begin
                        turbo_next = turbo_reg + 1'b1;
                        if (turbo_next > turbo_timeout_reg) begin
                            mode_next = step_down(mode_reg);
                        end
                    end
                    if (s_tuser) begin
                        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                            win_next[i] = win_reg[i + 1];
                        end
                        win_next[WINDOW_DEPTH - 1] = sample;
                        for (int i = 0; i < WINDOW_DEPTH; i++) begin
                            sum = sum + SUM_W'(win_next[i]);
                        end
                        avg = sum[SUM_W-1 -: 8];
                        thr = (mode_next == MODE_W'(1)) ? crit_thr_reg : low_thr_reg;
                        lowc_next = (avg < thr) ? lowc_reg + 1'b1 : '0;
                        if (avg > green_thr_reg) begin
                            green_next = 1'b1;
                            red_next   = 1'b0;
                        end else if (avg > yellow_thr_reg) begin
                            green_next = 1'b1;
                            red_next   = 1'b1;
                        end else begin
                            green_next = 1'b0;
                            red_next   = 1'b1;
                        end
                        if (cd_reg > 3'd1) begin
                            cd_next = cd_reg - 1'b1;
                        end else if (cd_reg == 3'd1) begin
                            for (int i = 0; i < 5; i++) begin
                                blinks = blinks + 3'(avg > BLINK_MARKS[i]);
                            end
                            done    = 1'b1;
                            cd_next = '0;
                        end
                    end
                    if (lowc_next >= lowbatt_delay_reg) begin
                        mode_next = step_down(mode_next);
                        lowc_next = '0;
                    end
                end
                press_next = '0;
            end

            if (mode_next != '0) begin
                fast_next = FAST_TABLE[mode_next];
            end

            if (mode_next != '0) begin
                pend_next = 1'b0;
            end else if (mode_reg != '0) begin
                pend_next = 1'b1;
            end
            if (pend_next && cd_next == '0) begin
                sleep_next = 1'b1;
                pend_next  = 1'b0;
                press_next = '0;
                green_next = 1'b0;
                red_next   = 1'b0;
            end
        end

        level = (cd_next != '0) ? 8'd0 : LEVEL_TABLE[mode_next];

        m_tdata_next                               = '0;
        m_tdata_next[OUT_MODE_LSB +: MODE_W]       = mode_next;
        m_tdata_next[OUT_LEVEL_LSB +: 8]           = level;
        m_tdata_next[OUT_FAST_BIT]                 = fast_next;
        m_tdata_next[OUT_GREEN_BIT]                = green_next;
        m_tdata_next[OUT_RED_BIT]                  = red_next;
        m_tdata_next[OUT_BLINKS_LSB +: 3]          = blinks;
        m_tdata_next[OUT_ASLEEP_BIT]               = sleep_next;
        m_tuser_next                               = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg     <= '0;
            press_reg    <= '0;
            on_time_reg  <= '0;
            turbo_reg    <= '0;
            lowc_reg     <= '0;
            mode_reg     <= '0;
            cd_reg       <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                win_reg[i] <= WINDOW_RESET;
            end
            sleep_reg    <= 1'b1;
            fast_reg     <= 1'b0;
            green_reg    <= 1'b0;
            red_reg      <= 1'b0;
            pend_reg     <= 1'b0;
        end else if (accept) begin
            hist_reg     <= hist_next;
            press_reg    <= press_next;
            on_time_reg  <= on_time_next;
            turbo_reg    <= turbo_next;
            lowc_reg     <= lowc_next;
            mode_reg     <= mode_next;
            cd_reg       <= cd_next;
            win_reg      <= win_next;
            sleep_reg    <= sleep_next;
            fast_reg     <= fast_next;
            green_reg    <= green_next;
            red_reg      <= red_next;
            pend_reg     <= pend_next;
        end
    end

    // hold the result until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ----- src/elmc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "eswitch_light_mode_controller_defines.svh"

module elmc_checker #(
    parameter int NUM_MODES = 7
) (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [elmc_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                            m_tuser
);
    import elmc_pkg::*;

    logic [MODE_W-1:0] mode;
    logic [2:0]        blinks;
    logic              asleep;
    logic              green;
    logic              red;

    assign mode   = m_tdata[OUT_MODE_LSB +: MODE_W];
    assign blinks = m_tdata[OUT_BLINKS_LSB +: 3];
    assign asleep = m_tdata[OUT_ASLEEP_BIT];
    assign green  = m_tdata[OUT_GREEN_BIT];
    assign red    = m_tdata[OUT_RED_BIT];

    `ELMC_ASSERT_RST(a_reset_empties, !aresetn |=> !m_tvalid, "result valid after reset")

    `ELMC_ASSERT(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled transfer changed")

    `ELMC_ASSERT(a_mode_range, m_tvalid |-> ({1'b0, mode} < (MODE_W + 1)'(NUM_MODES)), "mode beyond top mode")

    `ELMC_ASSERT(a_blinks, m_tvalid |-> (m_tuser ? (blinks <= MAX_BLINKS) : (blinks == '0)), "blink count inconsistent with readout")

    `ELMC_ASSERT(a_sleep_dark, m_tvalid && asleep |-> mode == '0 && !green && !red, "lit while asleep")

endmodule

bind eswitch_light_mode_controller elmc_checker #(.NUM_MODES(NUM_MODES)) u_elmc_checker (.*);

`default_nettype wire
